// ----- rtl/core/bgi_pkg.sv -----
`default_nettype none
package bgi_pkg;

  localparam int MAX_X_POINTS = 64;
  localparam int MAX_Y_POINTS = 64;
  localparam int XAW = $clog2(MAX_X_POINTS);
  localparam int YAW = $clog2(MAX_Y_POINTS);
  localparam int GAW = XAW + YAW;
  localparam int CNT_W = 7;
  localparam int VAL_W = 32;
  // divider: |q - lo| << 16 over |hi - lo|
  localparam int DEN_W = VAL_W + 1;
  localparam int NUM_W = DEN_W + 16;

  localparam logic [1:0] OP_WR_X = 2'd0;
  localparam logic [1:0] OP_WR_Y = 2'd1;
  localparam logic [1:0] OP_WR_GRID = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic CFG_X_POINTS = 1'b0;
  localparam logic CFG_Y_POINTS = 1'b1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // clip to signed 32 bits; MSB of the result flags a clip
  function automatic logic [VAL_W:0] sat32(input logic signed [50:0] v);
    logic [VAL_W:0] r;
    if (v > 51'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -51'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[VAL_W-1:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bgi_ram.sv -----
`default_nettype none
module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/bgi_div.sv -----
`default_nettype none
module bgi_div
  import bgi_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire div_req_t         req_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;

  // one quotient bit a cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]} - {1'b0, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      cnt_d  = CW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DEN_W]) begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      den_q <= req_i.den;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ----- rtl/core/bilinear_grid_interpolator.sv -----
`default_nettype none
// Bilinear interpolator on a rectilinear grid, Q16.16 signed.
// Input channel (in_valid_i / in_stall_o) carries one word per item: op
// selects an x axis write, a y axis write, a grid write (row x_index_i,
// column y_index_i) or a query at (query_x_i, query_y_i). Writes leave
// the input ready and give no result. A query gives one word on the output
// channel (out_valid_o / out_stall_i): the blended value and a status
// (ok, zero-width segment, saturated).
// A query holds in_stall_o high until its result enters the output
// register: per axis a binary search of up to 7 probes through the axis
// RAM read port, then a 49-step restoring divider for the fraction; the
// three blends share one 33x17 multiplier, two passes each. Axis and grid
// stores are undefined after reset; load them before querying. Point
// counts come from the configuration port and reset to 2.
// Reset clears the sequencer and the output valid. A finished result
// waits in the output register while out_stall_i is high; the input side
// keeps taking writes and a new query meanwhile, and that query holds at
// its last step until the output register frees.
module bilinear_grid_interpolator
  import bgi_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [5:0]        x_index_i,
  input  wire logic [5:0]        y_index_i,
  input  wire logic [31:0]       write_value_i,
  input  wire logic [31:0]       query_x_i,
  input  wire logic [31:0]       query_y_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [31:0]       result_value_o,
  output logic      [1:0]        status_o,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_index_i,
  input  wire logic [CNT_W-1:0]  cfg_data_i
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_AX0  = 5'd1;
  localparam logic [4:0] S_AX1  = 5'd2;
  localparam logic [4:0] S_ASC  = 5'd3;
  localparam logic [4:0] S_SADR = 5'd4;
  localparam logic [4:0] S_SCMP = 5'd5;
  localparam logic [4:0] S_LO   = 5'd6;
  localparam logic [4:0] S_HI   = 5'd7;
  localparam logic [4:0] S_FDIV = 5'd8;
  localparam logic [4:0] S_FWT  = 5'd9;
  localparam logic [4:0] S_G0   = 5'd10;
  localparam logic [4:0] S_G1   = 5'd11;
  localparam logic [4:0] S_G2   = 5'd12;
  localparam logic [4:0] S_G3   = 5'd13;
  localparam logic [4:0] S_G4   = 5'd14;
  localparam logic [4:0] S_MSUB = 5'd15;
  localparam logic [4:0] S_MLO  = 5'd16;
  localparam logic [4:0] S_MHI  = 5'd17;
  localparam logic [4:0] S_MRND = 5'd18;
  localparam logic [4:0] S_MADD = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  logic [4:0]       state_q, state_d;
  logic             ax_q, ax_d;
  logic [1:0]       lc_q, lc_d;
  logic [CNT_W-1:0] xpts_q, ypts_q;
  logic             out_valid_q, out_valid_d;

  logic [VAL_W-1:0] qx_q, qy_q, first_q, lo_q;
  logic             asc_q, neg_q, zero_q, sat_q;
  logic [CNT_W-1:0] base_q, len_q;
  logic [XAW-1:0]   mid_q;
  logic [XAW-1:0]   kx_q, ky_q;
  logic [DEN_W-1:0] num_q, dw_q;
  logic [VAL_W-1:0] tt_q, uu_q;
  logic [VAL_W-1:0] z1_q, z2_q, z3_q, z4_q;
  logic signed [DEN_W-1:0] d_q;
  logic signed [64:0]      acc_q;
  logic [VAL_W-1:0] res_q;
  logic [VAL_W-1:0] result_q;
  logic [1:0]       status_q;

  logic             in_acc;
  logic [CNT_W-1:0] nx, ny, n, half, mid;
  logic [XAW-1:0]   kcl, k, ax_raddr;
  logic [VAL_W-1:0] x_rdata, y_rdata, ax_rdata, g_rdata, q, p0, p1, t;
  logic [GAW-1:0]   g_raddr;
  logic             beyond, div_done;
  logic [NUM_W-1:0] quo;
  div_req_t         dreq;
  logic signed [NUM_W:0] fv;
  logic [VAL_W:0]   fsat, lsat;
  logic signed [50:0] lsum;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] depth);
    logic [CNT_W-1:0] c;
    if (r < CNT_W'(2)) begin
      c = CNT_W'(2);
    end else if (r > depth) begin
      c = depth;
    end else begin
      c = r;
    end
    return c;
  endfunction

  assign in_acc = in_valid_i && !in_stall_o;
  assign nx = clamp_cnt(xpts_q, CNT_W'(MAX_X_POINTS));
  assign ny = clamp_cnt(ypts_q, CNT_W'(MAX_Y_POINTS));
  assign n = ax_q ? ny : nx;
  assign half = len_q >> 1;
  assign mid = base_q + half;
  assign q = ax_q ? qy_q : qx_q;
  assign k = ax_q ? ky_q : kx_q;
  assign ax_rdata = ax_q ? y_rdata : x_rdata;
  assign beyond = asc_q ? ($signed(q) < $signed(ax_rdata))
                        : ($signed(q) > $signed(ax_rdata));

  always_comb begin
    if (base_q >= n) begin
      kcl = XAW'(n - 1'b1);
    end else if (base_q == '0) begin
      kcl = XAW'(1);
    end else begin
      kcl = base_q[XAW-1:0];
    end
  end

  always_comb begin
    case (state_q)
      S_AX0:   ax_raddr = '0;
      S_AX1:   ax_raddr = XAW'(n - 1'b1);
      S_SADR:  ax_raddr = (len_q == '0) ? kcl - 1'b1 : mid[XAW-1:0];
      S_LO:    ax_raddr = k;
      default: ax_raddr = '0;
    endcase
  end

  always_comb begin
    case (state_q)
      S_G0:    g_raddr = {kx_q - 1'b1, ky_q - 1'b1};
      S_G1:    g_raddr = {kx_q, ky_q - 1'b1};
      S_G2:    g_raddr = {kx_q, ky_q};
      default: g_raddr = {kx_q - 1'b1, ky_q};
    endcase
  end

  bgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_X_POINTS)) u_xram (
    .clk_i   (clk_i),
    .we_i    (in_acc && op_i == OP_WR_X),
    .waddr_i (x_index_i),
    .wdata_i (write_value_i),
    .raddr_i (ax_raddr),
    .rdata_o (x_rdata)
  );

  bgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_Y_POINTS)) u_yram (
    .clk_i   (clk_i),
    .we_i    (in_acc && op_i == OP_WR_Y),
    .waddr_i (y_index_i),
    .wdata_i (write_value_i),
    .raddr_i (ax_raddr),
    .rdata_o (y_rdata)
  );

  bgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_X_POINTS * MAX_Y_POINTS)) u_gram (
    .clk_i   (clk_i),
    .we_i    (in_acc && op_i == OP_WR_GRID),
    .waddr_i ({x_index_i, y_index_i}),
    .wdata_i (write_value_i),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  always_comb begin
    dreq.start = (state_q == S_FDIV) && (dw_q != '0);
    dreq.num   = {(num_q[DEN_W-1] ? -num_q : num_q), 16'h0000};
    dreq.den   = dw_q[DEN_W-1] ? -dw_q : dw_q;
  end

  bgi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign fv = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign fsat = sat32(51'(fv));

  always_comb begin
    case (lc_q)
      2'd0: begin
        p0 = z1_q; p1 = z2_q; t = tt_q;
      end
      2'd1: begin
        p0 = z4_q; p1 = z3_q; t = tt_q;
      end
      default: begin
        p0 = z1_q; p1 = z4_q; t = uu_q;
      end
    endcase
  end

  assign lsum = 51'($signed(p0)) + 51'($signed(acc_q[49:0]));
  assign lsat = sat32(lsum);

  // sequencer
  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    lc_d        = lc_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc && op_i == OP_QUERY) begin
          ax_d    = 1'b0;
          state_d = S_AX0;
        end
      end
      S_AX0:  state_d = S_AX1;
      S_AX1:  state_d = S_ASC;
      S_ASC:  state_d = S_SADR;
      S_SADR: state_d = (len_q == '0) ? S_LO : S_SCMP;
      S_SCMP: state_d = S_SADR;
      S_LO:   state_d = S_HI;
      S_HI:   state_d = S_FDIV;
      S_FDIV: begin
        if (dw_q != '0) begin
          state_d = S_FWT;
        end else begin
          ax_d    = 1'b1;
          state_d = ax_q ? S_G0 : S_AX0;
        end
      end
      S_FWT: begin
        if (div_done) begin
          ax_d    = 1'b1;
          state_d = ax_q ? S_G0 : S_AX0;
        end
      end
      S_G0: state_d = S_G1;
      S_G1: state_d = S_G2;
      S_G2: state_d = S_G3;
      S_G3: state_d = S_G4;
      S_G4: begin
        lc_d    = 2'd0;
        state_d = S_MSUB;
      end
      S_MSUB: state_d = S_MLO;
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_MRND;
      S_MRND: state_d = S_MADD;
      S_MADD: begin
        lc_d    = lc_q + 1'b1;
        state_d = (lc_q == 2'd2) ? S_DONE : S_MSUB;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= 1'b0;
      lc_q        <= 2'd0;
      out_valid_q <= 1'b0;
      xpts_q      <= CNT_W'(2);
      ypts_q      <= CNT_W'(2);
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      lc_q        <= lc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_index_i == CFG_X_POINTS) begin
        xpts_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_Y_POINTS) begin
        ypts_q <= cfg_data_i;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        qx_q   <= query_x_i;
        qy_q   <= query_y_i;
        zero_q <= 1'b0;
        sat_q  <= 1'b0;
      end
      S_AX1: first_q <= ax_rdata;
      S_ASC: begin
        asc_q  <= $signed(first_q) < $signed(ax_rdata);
        base_q <= '0;
        len_q  <= n;
      end
      S_SADR: begin
        mid_q <= mid[XAW-1:0];
        if (len_q == '0) begin
          if (ax_q) begin
            ky_q <= kcl;
          end else begin
            kx_q <= kcl;
          end
        end
      end
      S_SCMP: begin
        if (!beyond) begin
          base_q <= CNT_W'(mid_q) + 1'b1;
          len_q  <= len_q - half - 1'b1;
        end else begin
          len_q <= half;
        end
      end
      S_LO: lo_q <= ax_rdata;
      S_HI: begin
        num_q <= {q[VAL_W-1], q} - {lo_q[VAL_W-1], lo_q};
        dw_q  <= {ax_rdata[VAL_W-1], ax_rdata} - {lo_q[VAL_W-1], lo_q};
      end
      S_FDIV: begin
        neg_q <= num_q[DEN_W-1] ^ dw_q[DEN_W-1];
        if (dw_q == '0) begin
          zero_q <= 1'b1;
          if (ax_q) begin
            uu_q <= '0;
          end else begin
            tt_q <= '0;
          end
        end
      end
      S_FWT: begin
        if (div_done) begin
          sat_q <= sat_q | fsat[VAL_W];
          if (ax_q) begin
            uu_q <= fsat[VAL_W-1:0];
          end else begin
            tt_q <= fsat[VAL_W-1:0];
          end
        end
      end
      S_G1: z1_q <= g_rdata;
      S_G2: z2_q <= g_rdata;
      S_G3: z3_q <= g_rdata;
      S_G4: z4_q <= g_rdata;
      S_MSUB: d_q <= $signed({p1[VAL_W-1], p1}) - $signed({p0[VAL_W-1], p0});
      S_MLO: acc_q <= 65'(d_q * $signed({1'b0, t[15:0]}));
      S_MHI: acc_q <= acc_q + (65'(d_q * $signed(t[31:16])) <<< 16);
      S_MRND: acc_q <= (acc_q + 65'sd32768) >>> 16;
      S_MADD: begin
        sat_q <= sat_q | lsat[VAL_W];
        case (lc_q)
          2'd0:    z1_q <= lsat[VAL_W-1:0];
          2'd1:    z4_q <= lsat[VAL_W-1:0];
          default: res_q <= lsat[VAL_W-1:0];
        endcase
      end
      default: ;
    endcase
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      result_q <= res_q;
      status_q <= sat_q ? ST_SAT : (zero_q ? ST_ZERO : ST_OK);
    end
  end

  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/bgi_checker.sv -----
`default_nettype none
module bgi_checker
  import bgi_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic [1:0]       op_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [1:0]       status_o
);

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i == OP_QUERY |=> in_stall_o)
    else $error("query did not occupy the block");

  // a store write leaves the block ready
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i != OP_QUERY |=> !in_stall_o)
    else $error("write left the block busy");

  // a result appears only when a query finishes
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a query");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_ZERO || status_o == ST_SAT))
    else $error("bad status code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled word dropped");

endmodule

bind bilinear_grid_interpolator bgi_checker u_bgi_checker (.*);
`default_nettype wire
